@@ sv/integer_alu_seven_op_defines.svh @@
// Assertion macros for the integer ALU.
// Users must have clk and rst_n in scope where the macros expand.
`ifndef INTEGER_ALU_SEVEN_OP_DEFINES_SVH
`define INTEGER_ALU_SEVEN_OP_DEFINES_SVH

// Check a property while out of reset.
`define IALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define IALU_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ialu_pkg.sv @@
// Types, codes and sizing constants of the integer ALU.
// No dependencies; imported by integer_alu_seven_op.
package ialu_pkg;

  localparam int DW    = 32;          // operand width
  localparam int NS    = 8;           // iterative work stages
  localparam int DBS   = DW / NS;     // quotient bits per stage
  localparam int RT_W  = DW / 2;      // root width
  localparam int SQS   = RT_W / NS;   // root bits per stage
  localparam int RM_W  = RT_W + 2;    // root remainder width
  localparam int EXP_W = $clog2(DW);  // exponent bits that can avoid overflow

  localparam logic [2:0] OP_NONE = 3'd0;  // not an operation: bad opcode
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_POW  = 3'd5;
  localparam logic [2:0] OP_MOD  = 3'd6;
  localparam logic [2:0] OP_SQRT = 3'd7;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DIV0  = 3'd1;
  localparam logic [2:0] ST_NEGRT = 3'd2;
  localparam logic [2:0] ST_OVF   = 3'd3;
  localparam logic [2:0] ST_ZNEG  = 3'd4;
  localparam logic [2:0] ST_BADOP = 3'd5;

  // Which unit supplies the final result.
  localparam logic [2:0] SEL_PRE  = 3'd0;
  localparam logic [2:0] SEL_POW  = 3'd1;
  localparam logic [2:0] SEL_DIV  = 3'd2;
  localparam logic [2:0] SEL_MOD  = 3'd3;
  localparam logic [2:0] SEL_SQRT = 3'd4;

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [15:0]        second_root;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       sel;
    logic [DW-1:0]    pre_res;
    logic [2:0]       pre_st;
    logic             neg;
    logic [DW-1:0]    dv_rem;
    logic [DW-1:0]    dv_dvd;
    logic [DW-1:0]    dv_den;
    logic [DW-1:0]    dv_quo;
    logic [RM_W-1:0]  sa_rem;
    logic [DW-1:0]    sa_x;
    logic [RT_W-1:0]  sa_q;
    logic [RM_W-1:0]  sb_rem;
    logic [DW-1:0]    sb_x;
    logic [RT_W-1:0]  sb_q;
    logic [DW-1:0]    pw_acc;
    logic [DW-1:0]    pw_base;
    logic [DW-1:0]    pw_lim;
    logic [EXP_W-1:0] pw_exp;
    logic             pw_big;
    logic             pw_ovf;
  } stage_t;

endpackage

@@ sv/integer_alu_seven_op.sv @@
// Pipelined signed integer ALU: add, sub, mul, div, power, mod, dual sqrt.
// Depends on ialu_pkg and integer_alu_seven_op_defines.svh.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------
//   in      | in  | in_valid/in_stall  | in_data  (req_type, operand_a/b)
//   out     | out | out_valid/out_stall| out_data (result, second_root,
//           |     |                    |           status)
//
// Prep, work stages, output; one transaction enters per cycle unless stalled.
// The eight work stages each retire four quotient bits, two root bits of
// each operand and one bit of the power ladder (two multipliers per stage).
// Reset clears only the valid bits; payload registers are not reset.
// A stall at the output holds the output register; bubbles ahead of it still
// collapse, so in_stall rises only when every stage holds a transaction.
`include "integer_alu_seven_op_defines.svh"

module integer_alu_seven_op (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ialu_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ialu_pkg::out_item_t out_data
);
  import ialu_pkg::*;

  stage_t    pipe_r [NS+1];
  logic [NS:0] vld_r;
  logic      out_valid_r;
  out_item_t out_r;
  logic [NS+1:0] adv;

  // Decode the request, take magnitudes and settle every case that needs no
  // iteration (add, sub, zero divisor, negative root, trivial powers, bad opcode).
  function automatic stage_t prep(in_item_t x);
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic [DW:0]          s;
    logic [DW-1:0]        ma;
    logic [DW-1:0]        mb;
    logic                 an;
    logic                 bn;
    stage_t               p;
    a  = x.operand_a[DW-1:0];
    b  = x.operand_b[DW-1:0];
    an = a[DW-1];
    bn = b[DW-1];
    ma = an ? DW'(~a + 1'b1) : a;
    mb = bn ? DW'(~b + 1'b1) : b;
    s  = '0;
    p  = '0;
    p.sel     = SEL_PRE;
    p.pre_st  = ST_OK;
    p.dv_dvd  = ma;
    p.dv_den  = mb;
    p.sa_x    = a;
    p.sb_x    = b;
    p.pw_acc  = ma;
    p.pw_base = mb;
    p.pw_exp  = EXP_W'(1);
    unique case (x.req_type) inside
      OP_ADD, OP_SUB: begin
        if (x.req_type == OP_ADD) begin
          s = {a[DW-1], a} + {b[DW-1], b};
        end else begin
          s = {a[DW-1], a} - {b[DW-1], b};
        end
        if (s[DW] != s[DW-1]) begin
          p.pre_res = s[DW] ? SMIN : SMAX;
          p.pre_st  = ST_OVF;
        end else begin
          p.pre_res = s[DW-1:0];
        end
      end
      OP_MUL: begin
        // one ladder step with acc = |a| and base = |b|
        p.sel = SEL_POW;
        p.neg = an ^ bn;
      end
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          p.pre_st = ST_DIV0;
        end else begin
          p.sel = (x.req_type == OP_DIV) ? SEL_DIV : SEL_MOD;
          p.neg = (x.req_type == OP_DIV) ? (an ^ bn) : an;
        end
      end
      OP_POW: begin
        if (bn) begin
          if (a == 0) begin
            p.pre_st = ST_ZNEG;
          end else if (a == 1) begin
            p.pre_res = DW'(1);
          end else if (a == -1) begin
            p.pre_res = b[0] ? '1 : DW'(1);
          end
        end else if (b == 0) begin
          p.pre_res = DW'(1);
        end else if (a == 0 || a == 1) begin
          p.pre_res = a;
        end else if (a == -1) begin
          p.pre_res = b[0] ? '1 : DW'(1);
        end else begin
          p.neg = an & b[0];
          if (b[DW-1:EXP_W] != '0) begin
            // |a| >= 2 with a large exponent always leaves the range
            p.pre_res = p.neg ? SMIN : SMAX;
            p.pre_st  = ST_OVF;
          end else begin
            p.sel     = SEL_POW;
            p.pw_acc  = DW'(1);
            p.pw_base = ma;
            p.pw_exp  = b[EXP_W-1:0];
          end
        end
      end
      OP_SQRT: begin
        if (an || bn) begin
          p.pre_st = ST_NEGRT;
        end else begin
          p.sel = SEL_SQRT;
        end
      end
      default: begin
        p.pre_st = ST_BADOP;
      end
    endcase
    p.pw_lim = p.neg ? SMIN : SMAX;
    return p;
  endfunction

  // One work stage: restoring division, digit-by-digit roots, one ladder bit.
  function automatic stage_t step(stage_t p);
    logic [DW:0]     t;
    logic [RM_W+1:0] r2;
    logic [RM_W+1:0] tr;
    logic [2*DW-1:0] prod;
    logic [2*DW-1:0] sq;
    stage_t          n;
    n = p;
    for (int i = 0; i < DBS; i++) begin
      t        = {n.dv_rem, n.dv_dvd[DW-1]};
      n.dv_dvd = n.dv_dvd << 1;
      if (t >= {1'b0, n.dv_den}) begin
        n.dv_rem = DW'(t - {1'b0, n.dv_den});
        n.dv_quo = {n.dv_quo[DW-2:0], 1'b1};
      end else begin
        n.dv_rem = t[DW-1:0];
        n.dv_quo = {n.dv_quo[DW-2:0], 1'b0};
      end
    end
    for (int i = 0; i < SQS; i++) begin
      r2     = {n.sa_rem, n.sa_x[DW-1 -: 2]};
      tr     = {2'b00, n.sa_q, 2'b01};
      n.sa_x = n.sa_x << 2;
      if (r2 >= tr) begin
        n.sa_rem = RM_W'(r2 - tr);
        n.sa_q   = {n.sa_q[RT_W-2:0], 1'b1};
      end else begin
        n.sa_rem = r2[RM_W-1:0];
        n.sa_q   = {n.sa_q[RT_W-2:0], 1'b0};
      end
      r2     = {n.sb_rem, n.sb_x[DW-1 -: 2]};
      tr     = {2'b00, n.sb_q, 2'b01};
      n.sb_x = n.sb_x << 2;
      if (r2 >= tr) begin
        n.sb_rem = RM_W'(r2 - tr);
        n.sb_q   = {n.sb_q[RT_W-2:0], 1'b1};
      end else begin
        n.sb_rem = r2[RM_W-1:0];
        n.sb_q   = {n.sb_q[RT_W-2:0], 1'b0};
      end
    end
    prod = p.pw_acc * p.pw_base;
    sq   = p.pw_base * p.pw_base;
    if (p.pw_exp[0]) begin
      if (p.pw_big || prod > {{DW{1'b0}}, p.pw_lim}) begin
        n.pw_ovf = 1'b1;
      end else begin
        n.pw_acc = prod[DW-1:0];
      end
    end
    n.pw_exp = p.pw_exp >> 1;
    // square only while exponent bits remain
    if (n.pw_exp != '0) begin
      if (sq > {{DW{1'b0}}, p.pw_lim}) begin
        n.pw_big = 1'b1;
      end else begin
        n.pw_base = sq[DW-1:0];
      end
    end
    return n;
  endfunction

  // Apply signs and saturation, pick the result.
  function automatic out_item_t finish(stage_t p);
    out_item_t o;
    o        = '0;
    o.status = ST_OK;
    unique case (p.sel)
      SEL_POW: begin
        if (p.pw_ovf) begin
          o.result = p.neg ? SMIN : SMAX;
          o.status = ST_OVF;
        end else begin
          o.result = p.neg ? DW'(~p.pw_acc + 1'b1) : p.pw_acc;
        end
      end
      SEL_DIV: begin
        // only MIN / -1 gives a positive quotient above MAX
        if (!p.neg && p.dv_quo[DW-1]) begin
          o.result = SMAX;
          o.status = ST_OVF;
        end else begin
          o.result = p.neg ? DW'(~p.dv_quo + 1'b1) : p.dv_quo;
        end
      end
      SEL_MOD: begin
        o.result = p.neg ? DW'(~p.dv_rem + 1'b1) : p.dv_rem;
      end
      SEL_SQRT: begin
        o.result      = {{(DW-RT_W){1'b0}}, p.sa_q};
        o.second_root = 16'(p.sb_q);
      end
      default: begin
        o.result = p.pre_res;
        o.status = p.pre_st;
      end
    endcase
    return o;
  endfunction

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    adv[NS+1] = !out_valid_r || !out_stall;
    for (int k = NS; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (adv[NS+1]) begin
        out_valid_r <= vld_r[NS];
      end
    end
  end

  // Payload: hold on stall, advance otherwise.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pipe_r[0] <= prep(in_data);
    end
    for (int k = 1; k <= NS; k++) begin
      if (adv[k]) begin
        pipe_r[k] <= step(pipe_r[k-1]);
      end
    end
    if (adv[NS+1]) begin
      out_r <= finish(pipe_r[NS]);
    end
  end

  `IALU_ASSERT(a_stall_full,
    in_stall |-> (&vld_r) && out_valid_r && out_stall,
    "input stalled with room in the pipe")
  `IALU_ASSERT(a_root_ok,
    out_valid_r && out_r.second_root != 0 |-> out_r.status == ST_OK,
    "second root with error status")
  `IALU_ASSERT(a_ovf_sat,
    out_valid_r && out_r.status == ST_OVF |-> out_r.result == SMAX || out_r.result == SMIN,
    "overflow without saturation")
  `IALU_ASSERT_ANY(a_rst_clear,
    !rst_n |=> !out_valid_r && vld_r == '0,
    "valid bits survive reset")

endmodule

@@ bench/tb_integer_alu_seven_op.sv @@
// Testbench for the integer_alu_seven_op pipelined ALU: directed corner cases, then random traffic.
// Each result is checked against a behavioral predictor built from ialu_pkg types.
// Depends on ialu_pkg and the integer_alu_seven_op RTL.
module tb_integer_alu_seven_op;
  timeunit 1ns;
  timeprecision 1ps;
  import ialu_pkg::*;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  out_item_t alu_expected_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int checked_count = 0;
  int cycle_count = 0;
  int op_seen[8];

  integer_alu_seven_op dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Floor square root by the digit-by-digit method.
  function automatic longint floor_root(longint n);
    longint root;
    longint bitv;
    root = 0;
    bitv = 64'sd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Clamp a wide result to int32 and flag overflow.
  function automatic void clamp32(longint v, inout out_item_t r);
    if (v > I32_MAX) begin
      r.result = SMAX;
      r.status = ST_OVF;
    end else if (v < I32_MIN) begin
      r.result = SMIN;
      r.status = ST_OVF;
    end else begin
      r.result = v[31:0];
    end
  endfunction

  // Compute the expected ALU transaction for one request.
  function automatic out_item_t alu_compute(in_item_t req);
    out_item_t r;
    longint a;
    longint b;
    longint acc;
    longint e;
    r = '0;
    r.status = ST_OK;
    a = req.operand_a;
    b = req.operand_b;
    case (req.req_type)
      OP_ADD: clamp32(a + b, r);
      OP_SUB: clamp32(a - b, r);
      OP_MUL: clamp32(a * b, r);
      OP_DIV: begin
        if (b == 0) r.status = ST_DIV0;
        else clamp32(a / b, r);
      end
      OP_MOD: begin
        if (b == 0) r.status = ST_DIV0;
        else r.result = 32'(a % b);
      end
      OP_POW: begin
        if (b < 0) begin
          if (a == 0) r.status = ST_ZNEG;
          else if (a == 1) r.result = 1;
          else if (a == -1) r.result = b[0] ? -32'sd1 : 32'sd1;
          else r.result = 0;
        end else if (b == 0) begin
          r.result = 1;
        end else if (a == 0 || a == 1) begin
          r.result = a[31:0];
        end else if (a == -1) begin
          r.result = b[0] ? -32'sd1 : 32'sd1;
        end else begin
          // |a| >= 2, so 32+ multiplies always leave the range; stop early.
          acc = 1;
          e = b;
          while (e > 0 && acc <= I32_MAX && acc >= I32_MIN) begin
            acc = acc * a;
            e = e - 1;
          end
          // the saturated side follows the sign of the full power
          if (acc > I32_MAX || acc < I32_MIN) begin
            r.result = (a < 0 && b[0]) ? SMIN : SMAX;
            r.status = ST_OVF;
          end else begin
            r.result = acc[31:0];
          end
        end
      end
      OP_SQRT: begin
        if (a < 0 || b < 0) begin
          r.status = ST_NEGRT;
        end else begin
          r.result = 32'(floor_root(a));
          r.second_root = 16'(floor_root(b));
        end
      end
      default: r.status = ST_BADOP;
    endcase
    return r;
  endfunction

  // Drive one transaction and hold it until accepted.
  task automatic send_request(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    in_item_t req;
    req.req_type = op;
    req.operand_a = a;
    req.operand_b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    alu_expected_q.push_back(alu_compute(req));
    op_seen[op]++;
    @(negedge clk);
  endtask

  // Randomly stall the result channel, changing only at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (alu_expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = alu_expected_q.pop_front();
        checked_count++;
        if (want.result !== out_data.result)
          $display("%0t: result expected %0d actual %0d", $time,
                   want.result, out_data.result);
        if (want.second_root !== out_data.second_root)
          $display("%0t: second_root expected %0d actual %0d", $time,
                   want.second_root, out_data.second_root);
        if (want.status !== out_data.status)
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_data.status);
        if (want !== out_data) error_count++;
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, alu_expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Corner operands: extremes and sign boundaries of both fields.
  task automatic test_directed_corners();
    send_request(OP_ADD, 32'h7fffffff, 32'd1);
    send_request(OP_ADD, 32'h80000000, 32'hffffffff);
    send_request(OP_SUB, 32'h80000000, 32'd1);
    send_request(OP_SUB, 32'h7fffffff, 32'hffffffff);
    send_request(OP_MUL, 32'h80000000, 32'hffffffff);
    send_request(OP_MUL, 32'h00010000, 32'hffff8000);
    send_request(OP_MUL, 32'h00010000, 32'h00008000);
    send_request(OP_DIV, 32'h80000000, 32'hffffffff);
    send_request(OP_DIV, 32'hfffffff9, 32'd2);
    send_request(OP_DIV, 32'd5, 32'd0);
    send_request(OP_MOD, 32'h80000000, 32'hffffffff);
    send_request(OP_MOD, 32'hfffffff9, 32'd2);
    send_request(OP_MOD, 32'd5, 32'd0);
    send_request(OP_POW, 32'd0, 32'd0);
    send_request(OP_POW, 32'd0, 32'hffffffff);
    send_request(OP_POW, 32'hffffffff, 32'hfffffffd);
    send_request(OP_POW, 32'd1, 32'h80000000);
    send_request(OP_POW, 32'd7, 32'hfffffffe);
    send_request(OP_POW, 32'hfffffffe, 32'd31);
    send_request(OP_POW, 32'hfffffffe, 32'd33);
    send_request(OP_POW, 32'hfffffffd, 32'd21);
    send_request(OP_POW, 32'd2, 32'd31);
    send_request(OP_POW, 32'd3, 32'h7fffffff);
    send_request(OP_SQRT, 32'h7fffffff, 32'd0);
    send_request(OP_SQRT, 32'hffffffff, 32'd4);
    send_request(OP_NONE, 32'h12345678, 32'h9abcdef0);
  endtask

  // Draw an operand: often small, sometimes an extreme, otherwise full range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h7fffffff - $urandom_range(2);
      1: return 32'h80000000 + $urandom_range(2);
      2, 3: return $urandom_range(8) - 4;
      4: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // Random mix over all opcodes, including the invalid one.
  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      send_request(3'($urandom_range(7)), pick_operand(), pick_operand());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (alu_expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    send_idle_pct = 29;
    recv_stall_pct = 83;
    test_random_mix(550);
    send_idle_pct = 83;
    recv_stall_pct = 29;
    test_random_mix(550);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_mix(550);
    wait_drained();
    $display("checked %0d results; add %0d sub %0d mul %0d div %0d", checked_count,
             op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL], op_seen[OP_DIV]);
    $display("pow %0d mod %0d sqrt %0d invalid %0d", op_seen[OP_POW], op_seen[OP_MOD],
             op_seen[OP_SQRT], op_seen[OP_NONE]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
